[rtl/core/datagram_record_deframer_assert.svh]
// ----------------------------------------------------------------------------
// Datagram record deframer assertion macros
// Concurrent assertion wrappers on clock and reset; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef DATAGRAM_RECORD_DEFRAMER_ASSERT_SVH
`define DATAGRAM_RECORD_DEFRAMER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define DGR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer assertion failed");
// next-cycle implication
`define DGR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer assertion failed");
`else
`define DGR_ASSERT_IMP(lbl, ante, cons)
`define DGR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/core/dgr_pkg.sv]
// ----------------------------------------------------------------------------
// Datagram record deframer package
// Shared constants, result codes, parser phase and payload types.
// ----------------------------------------------------------------------------
package dgr_pkg;

   localparam int HEADER_BYTES = 4;
   localparam int HDR_POS_W    = $clog2(HEADER_BYTES);

   localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd64;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_LAST    = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_SKIP    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rec_type;
      logic [7:0] rec_length;
      logic [7:0] byte_index;
      logic [7:0] payload_byte;
   } rsp_payload_type;

   typedef struct packed {
      phase_type              phase;
      logic [HDR_POS_W-1:0]   hdr_pos;
      logic [7:0]             rec_len;
      logic [7:0]             pay_pos;
   } parse_status_type;

endpackage

[rtl/core/dgr_if.sv]
// ----------------------------------------------------------------------------
// Datagram record deframer channel interfaces
// Valid/ready channels for inbound bytes and outbound results.
// ----------------------------------------------------------------------------
interface dgr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_of_datagram;

   modport source (output valid, output data_byte, output last_of_datagram, input ready);
   modport sink   (input valid, input data_byte, input last_of_datagram, output ready);
endinterface

interface dgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rec_type;
   logic [7:0] rec_length;
   logic [7:0] byte_index;
   logic [7:0] payload_byte;

   modport source (output valid, output kind, output rec_type, output rec_length,
                   output byte_index, output payload_byte, input ready);
   modport sink   (input valid, input kind, input rec_type, input rec_length,
                   input byte_index, input payload_byte, output ready);
endinterface

[rtl/core/dgr_parser.sv]
// ----------------------------------------------------------------------------
// Datagram record parser
// Per-byte header/payload/skip state machine and the payload size register.
// ----------------------------------------------------------------------------
module dgr_parser
   import dgr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             in_accept,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output logic             res_valid,
   output rsp_payload_type  res,
   output parse_status_type status
);

   logic [7:0]           max_ff;
   phase_type            phase_ff, phase_in;
   logic [HDR_POS_W-1:0] hdr_ff, hdr_in;
   logic [7:0]           type_ff, type_in;
   logic [7:0]           len_ff, len_in;
   logic [7:0]           pos_ff, pos_in;
   logic [8:0]           pos_inc;
   logic [HDR_POS_W:0]   hdr_inc;

   // payload size register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   assign pos_inc = {1'b0, pos_ff} + 9'd1;
   assign hdr_inc = {1'b0, hdr_ff} + (HDR_POS_W+1)'(1);

   // next state and result for one byte
   always_comb begin
      phase_in  = phase_ff;
      hdr_in    = hdr_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      pos_in    = pos_ff;
      res_valid = 1'b0;
      res.kind         = KIND_BYTE;
      res.rec_type     = type_ff;
      res.rec_length   = len_ff;
      res.byte_index   = pos_ff;
      res.payload_byte = in_byte;

      unique case (phase_ff)
         PH_PAYLOAD: begin
            res_valid = 1'b1;
            if (pos_inc >= {1'b0, len_ff}) begin
               res.kind = KIND_LAST;
               phase_in = PH_HEADER;
               pos_in   = '0;
            end else if (in_last) begin
               res.kind         = KIND_DISCARD;
               res.payload_byte = '0;
            end else begin
               pos_in = pos_inc[7:0];
            end
         end
         PH_SKIP: begin
            pos_in = pos_inc[7:0];
            if (pos_inc >= {1'b0, len_ff}) begin
               phase_in = PH_HEADER;
               pos_in   = '0;
            end
         end
         default: begin
            // capture type and length bytes, drop sequence bytes
            if (hdr_ff == HDR_POS_W'(0)) begin
               type_in = in_byte;
            end
            if (hdr_ff == HDR_POS_W'(1)) begin
               len_in = in_byte;
            end
            if (hdr_inc >= (HDR_POS_W+1)'(HEADER_BYTES)) begin
               hdr_in = '0;
               pos_in = '0;
               if (len_in == 8'd0) begin
                  phase_in = PH_HEADER;
               end else if (len_in <= max_ff) begin
                  phase_in = PH_PAYLOAD;
                  if (in_last) begin
                     res_valid        = 1'b1;
                     res.kind         = KIND_DISCARD;
                     res.rec_type     = type_in;
                     res.rec_length   = len_in;
                     res.byte_index   = '0;
                     res.payload_byte = '0;
                  end
               end else begin
                  phase_in = PH_SKIP;
               end
            end else begin
               phase_in = PH_HEADER;
               hdr_in   = hdr_inc[HDR_POS_W-1:0];
            end
         end
      endcase

      // end of datagram: restart the parser
      if (in_last) begin
         phase_in = PH_HEADER;
         hdr_in   = '0;
         type_in  = '0;
         len_in   = '0;
         pos_in   = '0;
      end
   end

   // advance parser state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         hdr_ff   <= '0;
         type_ff  <= '0;
         len_ff   <= '0;
         pos_ff   <= '0;
      end else if (in_accept) begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
      end
   end

   assign status.phase   = phase_ff;
   assign status.hdr_pos = hdr_ff;
   assign status.rec_len = len_ff;
   assign status.pay_pos = pos_ff;

endmodule

[rtl/core/dgr_out_skid.sv]
// ----------------------------------------------------------------------------
// Deframer result skid stage
// Result register plus one spare entry so the input side never waits on
// the receiver combinationally.
// ----------------------------------------------------------------------------
module dgr_out_skid
   import dgr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   input  rsp_payload_type push_data,
   output logic            push_ready,
   output logic            pop_valid,
   input  logic            pop_ready,
   output rsp_payload_type pop_data
);

   logic            main_vld_ff;
   logic            skid_vld_ff;
   rsp_payload_type main_ff;
   rsp_payload_type skid_ff;
   logic            pop;

   assign pop        = main_vld_ff & pop_ready;
   assign push_ready = ~skid_vld_ff;
   assign pop_valid  = main_vld_ff;
   assign pop_data   = main_ff;

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (push_valid) begin
         if (main_vld_ff && !pop) begin
            skid_vld_ff <= 1'b1;
         end else begin
            main_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         main_vld_ff <= 1'b0;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (pop) begin
            main_ff <= skid_ff;
         end
      end else if (push_valid) begin
         if (main_vld_ff && !pop) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule

[rtl/core/datagram_record_deframer.sv]
// ----------------------------------------------------------------------------
// Datagram record deframer
// Splits byte-wide datagrams into records and forwards their payload bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one datagram byte per transfer, last_of_datagram set on
//   the final byte. rsp_chan carries at most one result per input byte:
//   a payload byte, a payload byte completing its record, or a discard for a
//   record cut off by the datagram end. Header bytes, keepalives and
//   oversize records give no result.
//   csr_wr_en/csr_wr_data set the largest forwarded payload length; write
//   it only while the block is idle.
//   Throughput: one byte per cycle while req_chan.ready is high; the parser
//   updates combinationally and each result is registered in the output stage.
//   Reset puts the parser in its header phase and the limit back to 64.
//   When the receiver stalls, results collect in a two-entry output stage;
//   req_chan.ready drops once both entries are full and rises again in the
//   cycle after the receiver takes a result.
// ----------------------------------------------------------------------------
`include "datagram_record_deframer_assert.svh"

module datagram_record_deframer
   import dgr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   dgr_req_if.sink    req_chan,
   dgr_rsp_if.source  rsp_chan
);

   logic             req_accept;
   logic             res_valid;
   rsp_payload_type  res;
   rsp_payload_type  rsp_data;
   parse_status_type status;
   logic             push_ready;

   assign req_chan.ready = push_ready;
   assign req_accept     = req_chan.valid & push_ready;

   // parse one byte per transfer
   dgr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_accept   (req_accept),
      .in_byte     (req_chan.data_byte),
      .in_last     (req_chan.last_of_datagram),
      .res_valid   (res_valid),
      .res         (res),
      .status      (status)
   );

   // hold results for the receiver
   dgr_out_skid u_out_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_accept & res_valid),
      .push_data  (res),
      .push_ready (push_ready),
      .pop_valid  (rsp_chan.valid),
      .pop_ready  (rsp_chan.ready),
      .pop_data   (rsp_data)
   );

   assign rsp_chan.kind         = rsp_data.kind;
   assign rsp_chan.rec_type     = rsp_data.rec_type;
   assign rsp_chan.rec_length   = rsp_data.rec_length;
   assign rsp_chan.byte_index   = rsp_data.byte_index;
   assign rsp_chan.payload_byte = rsp_data.payload_byte;

   // checks
   `DGR_ASSERT_NXT(a_last_restarts, req_accept && req_chan.last_of_datagram,
      status.phase == PH_HEADER && status.hdr_pos == '0 && status.pay_pos == '0)
   `DGR_ASSERT_IMP(a_stall_only_when_full, !req_chan.ready, rsp_chan.valid)
   `DGR_ASSERT_IMP(a_payload_pos_in_record, status.phase == PH_PAYLOAD,
      status.pay_pos < status.rec_len)
   `DGR_ASSERT_IMP(a_discard_zero_byte, rsp_chan.valid && rsp_chan.kind == KIND_DISCARD,
      rsp_chan.payload_byte == 8'd0)

endmodule
